/* hdl/vec3_vector_alu_defines.svh */
// Assertion macros for the vec3 vector ALU.
`ifndef VEC3_VECTOR_ALU_DEFINES_SVH
`define VEC3_VECTOR_ALU_DEFINES_SVH
`ifndef SYNTHESIS
// check with reset masking
`define V3_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("vec3_vector_alu: check failed");
// check that also runs during reset
`define V3_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("vec3_vector_alu: reset check failed");
`else
`define V3_ASSERT(lbl, prop)
`define V3_ASSERT_NR(lbl, prop)
`endif
`endif

/* hdl/v3alu_pkg.sv */
// Types, codes and helpers for the vec3 vector ALU.
`default_nettype none
package v3alu_pkg;

    localparam int unsigned DW         = 32;
    localparam int unsigned LANES      = 3;
    localparam int unsigned SQ_STEPS   = 32;   // one root bit per stage
    localparam int unsigned DIV_STEPS  = 48;   // one quotient bit per stage
    localparam int unsigned QW         = 48;   // quotient / shifted dividend width
    localparam int unsigned WW         = 66;   // wide signed intermediate
    localparam int unsigned IN_TDATA_W = 224;
    localparam int unsigned IN_TUSER_W = 4;
    localparam int unsigned OUT_TDATA_W = 128;
    localparam int unsigned OUT_TUSER_W = 2;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_DOT   = 4'd4;
    localparam logic [3:0] OP_CROSS = 4'd5;
    localparam logic [3:0] OP_MAGSQ = 4'd6;
    localparam logic [3:0] OP_MAG   = 4'd7;
    localparam logic [3:0] OP_NORM  = 4'd8;
    localparam logic [3:0] OP_SADD  = 4'd9;
    localparam logic [3:0] OP_SSUB  = 4'd10;
    localparam logic [3:0] OP_SMUL  = 4'd11;
    localparam logic [3:0] OP_SDIV  = 4'd12;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_ZMAG = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic signed [WW-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [WW-1:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic [31:0] v;
        logic        f;
    } t_sat;

    // item state carried down the pipe
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] rv;    // results known early
        logic [31:0]      so;
        logic             sat;
        logic [2:0][31:0] amag;  // |a| per lane
        logic [2:0]       aneg;
        logic [2:0][31:0] dmag;  // divisor magnitude per lane
        logic [2:0]       dz;    // zero divisor per lane
        logic             zm;    // zero magnitude
    } t_item;

    function automatic t_sat sat32(input logic signed [WW-1:0] w);
        t_sat r;
        r.f = 1'b1;
        if (w > SAT_MAX) begin
            r.v = 32'h7fff_ffff;
        end else if (w < SAT_MIN) begin
            r.v = 32'h8000_0000;
        end else begin
            r.v = w[31:0];
            r.f = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? 32'(-x) : x;
    endfunction

endpackage
`default_nettype wire

/* hdl/vec3_vector_alu.sv */
// Top level of the vec3 vector ALU: pipelined Q16.16 vector arithmetic.
// Takes one request per clock while the output is not stalled: opcode on tuser, vectors a, b
// and a scalar on tdata, all signed Q16.16. Every request gives one result (vector, scalar,
// status), in order, from an output register. The depth is set by the square root (32
// stages, one root bit each) followed by the divider (48 stages, one quotient bit each,
// three lanes in parallel). Every opcode walks the full pipe, so order is kept for free. A
// stalled output freezes the whole pipe and drops s_axis tready; nothing is lost or repeated.
// Products are floored to Q16.16, quotients truncate toward zero, and all results saturate
// to 32 bits. Status: 0 ok, 1 divide by zero, 2 zero magnitude, 3 saturated. No
// configuration, no state beyond the pipe.
`default_nettype none
`include "vec3_vector_alu_defines.svh"
module vec3_vector_alu (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // ax, ay, az, bx, by, bz, scalar_in (32 bits each, lowest first)
    input  wire logic [v3alu_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // opcode
    input  wire logic [v3alu_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // rx, ry, rz, scalar_out (32 bits each, lowest first)
    output logic [v3alu_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // status
    output logic [v3alu_pkg::OUT_TUSER_W-1:0]       o_m_axis_tuser
);
    import v3alu_pkg::*;

    // global advance: whole pipe moves unless the output holds a result not yet taken
    logic ce;

    // stage 0: input register
    logic               r_s0_vld;
    logic [3:0]         r_s0_op;
    logic signed [31:0] r_s0_a [LANES];
    logic signed [31:0] r_s0_b [LANES];
    logic signed [31:0] r_s0_s;

    // stage 1: products
    logic signed [31:0] n_x [6];
    logic signed [31:0] n_y [6];
    logic signed [63:0] n_p [6];
    logic               r_s1_vld;
    logic [3:0]         r_s1_op;
    logic signed [31:0] r_s1_a [LANES];
    logic signed [31:0] r_s1_b [LANES];
    logic signed [31:0] r_s1_s;
    logic signed [63:0] r_s1_p [6];

    // stage 2 logic (feeds square root stage 0)
    logic signed [WW-1:0] w_lane [LANES];
    logic signed [WW-1:0] w_dot;
    logic [63:0]          w_sumsq;
    t_sat                 w_lsat [LANES];
    t_sat                 w_ssat;
    t_item                n_s2_item;

    // square root pipe, index 0 is the entry register
    logic [SQ_STEPS:0]  r_sq_vld;
    t_item              r_sq_item [SQ_STEPS+1];
    logic [63:0]        r_sq_n    [SQ_STEPS+1];
    logic [31:0]        r_sq_root [SQ_STEPS+1];
    logic [33:0]        r_sq_rem  [SQ_STEPS+1];
    t_item              n_sq_item [SQ_STEPS+1];
    logic [63:0]        n_sq_n    [SQ_STEPS+1];
    logic [31:0]        n_sq_root [SQ_STEPS+1];
    logic [33:0]        n_sq_rem  [SQ_STEPS+1];
    logic [35:0]        w_sq_t    [SQ_STEPS];
    logic [35:0]        w_sq_try  [SQ_STEPS];

    // divider pipe, index 0 is the setup register
    logic [DIV_STEPS:0] r_dv_vld;
    t_item              r_dv_item [DIV_STEPS+1];
    logic [31:0]        r_dv_rem  [DIV_STEPS+1][LANES];
    logic [QW-1:0]      r_dv_q    [DIV_STEPS+1][LANES];
    t_item              n_dv_item [DIV_STEPS+1];
    logic [31:0]        n_dv_rem  [DIV_STEPS+1][LANES];
    logic [QW-1:0]      n_dv_q    [DIV_STEPS+1][LANES];
    logic [32:0]        w_dv_t    [DIV_STEPS][LANES];
    logic [31:0]        w_m;
    t_sat               w_msat;

    // output
    t_sat                       w_fsat [LANES];
    logic [2:0][31:0]           w_fr;
    logic                       w_fany;
    logic                       r_out_vld;
    logic [OUT_TDATA_W-1:0]     r_out_data;
    logic [OUT_TUSER_W-1:0]     r_out_user;
    logic [OUT_TDATA_W-1:0]     n_out_data;
    logic [OUT_TUSER_W-1:0]     n_out_user;

    assign ce              = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // ---------------- stage 1 operand select ----------------
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_x[i] = r_s0_a[i];
            n_y[i] = r_s0_b[i];
        end
        case (r_s0_op)
            OP_MAGSQ, OP_MAG, OP_NORM: begin
                for (int i = 0; i < LANES; i++) n_y[i] = r_s0_a[i];
            end
            OP_SMUL: begin
                for (int i = 0; i < LANES; i++) n_y[i] = r_s0_s;
            end
            OP_CROSS: begin
                n_x[0] = r_s0_a[1]; n_y[0] = r_s0_b[2];
                n_x[1] = r_s0_a[2]; n_y[1] = r_s0_b[0];
                n_x[2] = r_s0_a[0]; n_y[2] = r_s0_b[1];
            end
            default: ;
        endcase
        // subtrahend terms of the cross product
        n_x[3] = r_s0_a[2]; n_y[3] = r_s0_b[1];
        n_x[4] = r_s0_a[0]; n_y[4] = r_s0_b[2];
        n_x[5] = r_s0_a[1]; n_y[5] = r_s0_b[0];
        for (int k = 0; k < 6; k++) n_p[k] = 64'(n_x[k]) * 64'(n_y[k]);
    end

    // ---------------- stage 2: sums, floors, early results ----------------
    always_comb begin
        w_sumsq = 64'(r_s1_p[0]) + 64'(r_s1_p[1]) + 64'(r_s1_p[2]);
        w_dot   = 66'(r_s1_p[0]) + 66'(r_s1_p[1]) + 66'(r_s1_p[2]);
        for (int i = 0; i < LANES; i++) begin
            case (r_s1_op)
                OP_ADD:           w_lane[i] = 66'(r_s1_a[i]) + 66'(r_s1_b[i]);
                OP_SUB:           w_lane[i] = 66'(r_s1_a[i]) - 66'(r_s1_b[i]);
                OP_SADD:          w_lane[i] = 66'(r_s1_a[i]) + 66'(r_s1_s);
                OP_SSUB:          w_lane[i] = 66'(r_s1_a[i]) - 66'(r_s1_s);
                OP_MUL, OP_SMUL:  w_lane[i] = 66'(r_s1_p[i] >>> 16);
                OP_CROSS:         w_lane[i] = (66'(r_s1_p[i]) - 66'(r_s1_p[i+3])) >>> 16;
                default:          w_lane[i] = '0;
            endcase
            w_lsat[i] = sat32(w_lane[i]);
        end
        case (r_s1_op)
            OP_DOT:   w_ssat = sat32(w_dot >>> 16);
            OP_MAGSQ: w_ssat = sat32(66'({16'h0, w_sumsq[63:16]}));
            default:  w_ssat = '0;
        endcase
        n_s2_item.op  = r_s1_op;
        n_s2_item.so  = w_ssat.v;
        n_s2_item.sat = w_ssat.f | w_lsat[0].f | w_lsat[1].f | w_lsat[2].f;
        for (int i = 0; i < LANES; i++) begin
            n_s2_item.rv[i]   = w_lsat[i].v;
            n_s2_item.amag[i] = abs32(r_s1_a[i]);
            // quotient sign: dividend sign, flipped by a negative divisor
            n_s2_item.aneg[i] = r_s1_a[i][31] ^
                                ((r_s1_op == OP_SDIV) ? r_s1_s[31] :
                                 ((r_s1_op == OP_DIV) & r_s1_b[i][31]));
            n_s2_item.dmag[i] = (r_s1_op == OP_SDIV) ? abs32(r_s1_s) : abs32(r_s1_b[i]);
        end
        n_s2_item.dz = '0;
        n_s2_item.zm = 1'b0;
    end

    // ---------------- square root: one result bit per stage ----------------
    always_comb begin
        n_sq_item[0] = n_s2_item;
        n_sq_n[0]    = w_sumsq;
        n_sq_root[0] = '0;
        n_sq_rem[0]  = '0;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            w_sq_t[k-1]   = {r_sq_rem[k-1], r_sq_n[k-1][63:62]};
            w_sq_try[k-1] = {2'b00, r_sq_root[k-1], 2'b01};
            n_sq_item[k]  = r_sq_item[k-1];
            n_sq_n[k]     = {r_sq_n[k-1][61:0], 2'b00};
            if (w_sq_t[k-1] >= w_sq_try[k-1]) begin
                n_sq_rem[k]  = 34'(w_sq_t[k-1] - w_sq_try[k-1]);
                n_sq_root[k] = {r_sq_root[k-1][30:0], 1'b1};
            end else begin
                n_sq_rem[k]  = w_sq_t[k-1][33:0];
                n_sq_root[k] = {r_sq_root[k-1][30:0], 1'b0};
            end
        end
    end

    // ---------------- divider setup and steps ----------------
    always_comb begin
        w_m          = r_sq_root[SQ_STEPS];
        w_msat       = sat32(66'({34'd0, w_m}));
        n_dv_item[0] = r_sq_item[SQ_STEPS];
        case (r_sq_item[SQ_STEPS].op)
            OP_MAG: begin
                n_dv_item[0].so  = w_msat.v;
                n_dv_item[0].sat = w_msat.f;
            end
            OP_NORM: begin
                for (int i = 0; i < LANES; i++) n_dv_item[0].dmag[i] = w_m;
                n_dv_item[0].zm = (w_m == '0);
            end
            OP_DIV, OP_SDIV: begin
                for (int i = 0; i < LANES; i++)
                    n_dv_item[0].dz[i] = (r_sq_item[SQ_STEPS].dmag[i] == '0);
            end
            default: ;
        endcase
        for (int i = 0; i < LANES; i++) begin
            n_dv_rem[0][i] = '0;
            n_dv_q[0][i]   = {r_sq_item[SQ_STEPS].amag[i], 16'h0};
        end
        // restoring division, dividend bits shift out of q as quotient bits shift in
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_dv_item[k] = r_dv_item[k-1];
            for (int i = 0; i < LANES; i++) begin
                w_dv_t[k-1][i] = {r_dv_rem[k-1][i], r_dv_q[k-1][i][QW-1]};
                if (w_dv_t[k-1][i] >= {1'b0, r_dv_item[k-1].dmag[i]}) begin
                    n_dv_rem[k][i] = 32'(w_dv_t[k-1][i] - {1'b0, r_dv_item[k-1].dmag[i]});
                    n_dv_q[k][i]   = {r_dv_q[k-1][i][QW-2:0], 1'b1};
                end else begin
                    n_dv_rem[k][i] = w_dv_t[k-1][i][31:0];
                    n_dv_q[k][i]   = {r_dv_q[k-1][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- final sign, saturation, status ----------------
    always_comb begin
        w_fany = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            w_fsat[i] = sat32(r_dv_item[DIV_STEPS].aneg[i] ?
                              66'(-66'({18'd0, r_dv_q[DIV_STEPS][i]})) :
                              66'({18'd0, r_dv_q[DIV_STEPS][i]}));
            case (r_dv_item[DIV_STEPS].op)
                OP_DIV, OP_SDIV, OP_NORM: begin
                    if (r_dv_item[DIV_STEPS].dz[i] || r_dv_item[DIV_STEPS].zm) begin
                        w_fr[i] = '0;
                    end else begin
                        w_fr[i] = w_fsat[i].v;
                        w_fany  = w_fany | w_fsat[i].f;
                    end
                end
                default: w_fr[i] = r_dv_item[DIV_STEPS].rv[i];
            endcase
        end
        n_out_data = {r_dv_item[DIV_STEPS].so, w_fr[2], w_fr[1], w_fr[0]};
        if (|r_dv_item[DIV_STEPS].dz) begin
            n_out_user = ST_DIV0;
        end else if (r_dv_item[DIV_STEPS].zm) begin
            n_out_user = ST_ZMAG;
        end else if (r_dv_item[DIV_STEPS].sat || w_fany) begin
            n_out_user = ST_SAT;
        end else begin
            n_out_user = ST_OK;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_sq_vld  <= '0;
            r_dv_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (ce) begin
            r_s0_vld  <= i_s_axis_tvalid;
            r_s1_vld  <= r_s0_vld;
            r_sq_vld  <= {r_sq_vld[SQ_STEPS-1:0], r_s1_vld};
            r_dv_vld  <= {r_dv_vld[DIV_STEPS-1:0], r_sq_vld[SQ_STEPS]};
            r_out_vld <= r_dv_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_s0_op <= i_s_axis_tuser;
            for (int i = 0; i < LANES; i++) begin
                r_s0_a[i] <= i_s_axis_tdata[32*i +: 32];
                r_s0_b[i] <= i_s_axis_tdata[96 + 32*i +: 32];
            end
            r_s0_s  <= i_s_axis_tdata[223:192];

            r_s1_op <= r_s0_op;
            r_s1_a  <= r_s0_a;
            r_s1_b  <= r_s0_b;
            r_s1_s  <= r_s0_s;
            r_s1_p  <= n_p;

            for (int k = 0; k <= SQ_STEPS; k++) begin
                r_sq_item[k] <= n_sq_item[k];
                r_sq_n[k]    <= n_sq_n[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_rem[k]  <= n_sq_rem[k];
            end
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_dv_item[k] <= n_dv_item[k];
                r_dv_rem[k]  <= n_dv_rem[k];
                r_dv_q[k]    <= n_dv_q[k];
            end

            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    // ---------------- checks ----------------
    `V3_ASSERT_NR(a_rst_out_idle, !i_rst_n |=> !o_m_axis_tvalid)
    `V3_ASSERT(a_zmag_vec_zero, o_m_axis_tvalid && o_m_axis_tuser == ST_ZMAG |-> o_m_axis_tdata[95:0] == '0)
    `V3_ASSERT(a_div0_so_zero, o_m_axis_tvalid && o_m_axis_tuser == ST_DIV0 |-> o_m_axis_tdata[127:96] == '0)
    `V3_ASSERT(a_zm_only_norm, r_dv_vld[0] && r_dv_item[0].zm |-> r_dv_item[0].op == OP_NORM)

endmodule
`default_nettype wire

/* test/vec3_vector_alu_chk.sv */
// Checker for the vec3 vector ALU: predicts each request's result and compares in order.
module vec3_vector_alu_chk (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_valid,
    input  wire logic                               i_s_ready,
    input  wire logic [v3alu_pkg::IN_TDATA_W-1:0]   i_s_data,
    input  wire logic [v3alu_pkg::IN_TUSER_W-1:0]   i_s_user,
    input  wire logic                               i_m_valid,
    input  wire logic                               i_m_ready,
    input  wire logic [v3alu_pkg::OUT_TDATA_W-1:0]  i_m_data,
    input  wire logic [v3alu_pkg::OUT_TUSER_W-1:0]  i_m_user,
    output int                                      o_errors,
    output int                                      o_pending
);
    import v3alu_pkg::*;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] so;
        logic [1:0]  st;
    } alu_result_t;

    alu_result_t results_due[$];

    function automatic logic [31:0] clamp(input logic signed [71:0] v, inout logic hit);
        if (v > 72'sd2147483647) begin
            hit = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -72'sd2147483648) begin
            hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // bitwise integer square root, floor
    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic alu_result_t vec_alu_predict(input logic [3:0] op,
                                                    input logic [223:0] d);
        logic signed [71:0] av [3];
        logic signed [71:0] bv [3];
        logic signed [71:0] sv;
        logic signed [71:0] t;
        logic signed [71:0] mv;
        logic [31:0]        r [3];
        logic [31:0]        so;
        logic [1:0]         st;
        logic               hit;
        logic [63:0]        m;
        alu_result_t        res;
        for (int i = 0; i < 3; i++) begin
            av[i] = $signed(d[32*i +: 32]);
            bv[i] = $signed(d[32*(i+3) +: 32]);
            r[i]  = '0;
        end
        sv  = $signed(d[192 +: 32]);
        so  = '0;
        st  = ST_OK;
        hit = 1'b0;
        t   = av[0]*av[0] + av[1]*av[1] + av[2]*av[2];
        m   = root64(t[63:0]);
        mv  = {8'd0, m};
        case (op)
            OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp(av[i] + bv[i], hit);
            OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp(av[i] - bv[i], hit);
            OP_MUL: for (int i = 0; i < 3; i++) r[i] = clamp((av[i]*bv[i]) >>> 16, hit);
            OP_DIV: begin
                // zero divisor only blanks its own lane
                for (int i = 0; i < 3; i++) begin
                    if (bv[i] == 0) st = ST_DIV0;
                    else r[i] = clamp((av[i] <<< 16) / bv[i], hit);
                end
            end
            OP_DOT:
                so = clamp((av[0]*bv[0] + av[1]*bv[1] + av[2]*bv[2]) >>> 16, hit);
            OP_CROSS: begin
                r[0] = clamp((av[1]*bv[2] - av[2]*bv[1]) >>> 16, hit);
                r[1] = clamp((av[2]*bv[0] - av[0]*bv[2]) >>> 16, hit);
                r[2] = clamp((av[0]*bv[1] - av[1]*bv[0]) >>> 16, hit);
            end
            OP_MAGSQ: so = clamp(t >>> 16, hit);
            OP_MAG:   so = clamp(mv, hit);
            OP_NORM: begin
                if (m == 0) st = ST_ZMAG;
                else for (int i = 0; i < 3; i++) r[i] = clamp((av[i] <<< 16) / mv, hit);
            end
            OP_SADD: for (int i = 0; i < 3; i++) r[i] = clamp(av[i] + sv, hit);
            OP_SSUB: for (int i = 0; i < 3; i++) r[i] = clamp(av[i] - sv, hit);
            OP_SMUL: for (int i = 0; i < 3; i++) r[i] = clamp((av[i]*sv) >>> 16, hit);
            OP_SDIV: begin
                if (sv == 0) st = ST_DIV0;
                else for (int i = 0; i < 3; i++) r[i] = clamp((av[i] <<< 16) / sv, hit);
            end
            default: ;
        endcase
        if (st == ST_OK && hit) st = ST_SAT;
        res.rx = r[0];
        res.ry = r[1];
        res.rz = r[2];
        res.so = so;
        res.st = st;
        return res;
    endfunction

    always @(posedge i_clk) begin
        alu_result_t want;
        alu_result_t got;
        if (i_rst_n && i_s_valid && i_s_ready)
            results_due.push_back(vec_alu_predict(i_s_user, i_s_data));
        if (i_rst_n && i_m_valid && i_m_ready) begin
            got = {i_m_data[31:0], i_m_data[63:32], i_m_data[95:64], i_m_data[127:96],
                   i_m_user};
            if (results_due.size() == 0) begin
                $display("%0t: result with none pending: %h", $time, got);
                o_errors <= o_errors + 1;
            end else begin
                want = results_due.pop_front();
                if (got != want) begin
                    $display("%0t: mismatch rx/ry/rz/so/st exp %h %h %h %h %0d got %h %h %h %h %0d",
                             $time, want.rx, want.ry, want.rz, want.so, want.st,
                             got.rx, got.ry, got.rz, got.so, got.st);
                    o_errors <= o_errors + 1;
                end
            end
        end
        o_pending <= results_due.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end
endmodule

/* test/tb.sv */
// Testbench top for the vec3 vector ALU: stimulus, back-pressure and verdict.
module tb;
    import v3alu_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [IN_TDATA_W-1:0]   s_data = '0;   // ax, ay, az, bx, by, bz, scalar_in
    logic [IN_TUSER_W-1:0]   s_user = '0;   // opcode
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_data;        // rx, ry, rz, scalar_out
    logic [OUT_TUSER_W-1:0]  m_user;        // status
    int                      errors;
    int                      pending;
    int                      results_taken = 0;
    logic                    stim_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vec3_vector_alu u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    vec3_vector_alu_chk u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_valid),
        .i_s_ready (s_ready),
        .i_s_data  (s_data),
        .i_s_user  (s_user),
        .i_m_valid (m_valid),
        .i_m_ready (m_ready),
        .i_m_data  (m_data),
        .i_m_user  (m_user),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // Q16.16 operand with a mix of magnitudes so saturation and tiny values both show up
    function automatic logic [31:0] pick_q();
        logic [31:0] v;
        case ($urandom_range(0, 6))
            0: v = $urandom_range(0, 32'h3ffff);
            1: v = $urandom_range(0, 32'h7f_ffff);
            2: case ($urandom_range(0, 5))
                   0: v = 32'h7fff_ffff;
                   1: v = 32'h8000_0000;
                   2: v = 32'h0001_0000;
                   3: v = 32'hffff_ffff;
                   4: v = 32'd1;
                   default: v = 32'hffff_0000;
               endcase
            3: v = 32'd0;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 1) && v != 32'h8000_0000) v = -v;
        return v;
    endfunction

    // one request; entered and left at a falling edge, valid kept high across back-to-back
    task automatic send_request(input logic [3:0] op, input logic [31:0] ax, ay, az,
                                input logic [31:0] bx, by, bz, sc, input bit bursty);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {sc, bz, by, bx, az, ay, ax};
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    // receiver: random stalls, idle-free stretches, and one long hold-off to fill the pipe
    initial begin
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (results_taken == 300) gap = 400;
            else if ((results_taken / 100) % 4 == 2) gap = 0;
            else gap = $urandom_range(0, 5);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
            results_taken++;
            @(negedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin
        logic [31:0] mx, mn, one;
        bit          bursty;
        logic [3:0]  op;
        logic [31:0] a0, a1, a2, b0, b1, b2, sc;
        mx  = 32'h7fff_ffff;
        mn  = 32'h8000_0000;
        one = 32'h0001_0000;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, each opcode, zero divisors, zero vector, unused codes
        send_request(OP_ADD,   mx, mn, one, mx, mn, one, 0, 0);
        send_request(OP_SUB,   mn, mx, 0, mx, mn, 0, 0, 0);
        send_request(OP_MUL,   mx, mn, mn, mx, mn, mx, 0, 0);
        send_request(OP_MUL,   one, -one, 3, 5, 7, -1, 0, 0);
        send_request(OP_DIV,   one, mx, -one, 0, 3, -7, 0, 0);
        send_request(OP_DIV,   mn, mx, 1, -one, 1, 0, 0, 0);
        send_request(OP_DOT,   mx, mx, mx, mx, mx, mx, 0, 0);
        send_request(OP_DOT,   mn, mn, mn, mx, mx, mx, 0, 0);
        send_request(OP_DOT,   one, -3, 1, 2, 5, -1, 0, 0);
        send_request(OP_CROSS, mx, mn, mx, mn, mx, mn, 0, 0);
        send_request(OP_CROSS, one, 0, 0, 0, one, 0, 0, 0);
        send_request(OP_MAGSQ, mn, mn, mn, 0, 0, 0, 0, 0);
        send_request(OP_MAGSQ, 1, -1, 1, 0, 0, 0, 0, 0);
        send_request(OP_MAG,   mn, mn, mn, 0, 0, 0, 0, 0);
        send_request(OP_MAG,   3, 4, 0, 0, 0, 0, 0, 0);
        send_request(OP_NORM,  0, 0, 0, 1, 2, 3, 4, 0);
        send_request(OP_NORM,  1, 0, 0, 0, 0, 0, 0, 0);
        send_request(OP_NORM,  mn, 5, -one, 0, 0, 0, 0, 0);
        send_request(OP_SADD,  mx, mn, 0, 0, 0, 0, mx, 0);
        send_request(OP_SSUB,  mn, mx, 0, 0, 0, 0, mx, 0);
        send_request(OP_SMUL,  mx, mn, one, 0, 0, 0, mn, 0);
        send_request(OP_SDIV,  one, mx, mn, 0, 0, 0, 0, 0);
        send_request(OP_SDIV,  mn, mx, one, 0, 0, 0, -1, 0);
        send_request(4'd13,    mx, mx, mx, mx, mx, mx, mx, 0);
        send_request(4'd15,    mn, mn, mn, mn, mn, mn, mn, 0);

        for (int n = 0; n < 1650; n++) begin
            bursty = ((n / 150) % 3 == 1);
            op = $urandom_range(0, 15);
            a0 = pick_q(); a1 = pick_q(); a2 = pick_q();
            b0 = pick_q(); b1 = pick_q(); b2 = pick_q();
            sc = pick_q();
            if (op == OP_NORM && $urandom_range(0, 7) == 0) begin
                a0 = 0; a1 = 0; a2 = 0;
            end
            send_request(op, a0, a1, a2, b0, b1, b2, sc, bursty);
        end
        s_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
